// ===== rtl/fust_pkg.sv =====
// shared constants and types of the first unique symbol tracker
`timescale 1ns / 1ps
package fust_pkg;

    // symbol and alphabet geometry
    localparam int SYM_W         = 8;
    localparam int ALPHABET_SIZE = 256;
    localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CNT_W         = $clog2(ALPHABET_SIZE + 1);

    // control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        logic             clear;
        logic             append;
        logic             shift;
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] tail;
        logic [IDX_W-1:0] rm_idx;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_FIND  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

// ===== rtl/fust_in_if.sv =====
// input channel: one stream symbol per transfer
`timescale 1ns / 1ps
interface fust_in_if;
    import fust_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             start_of_stream;

    modport source (output valid, output symbol, output start_of_stream, input ready);
    modport sink   (input valid, input symbol, input start_of_stream, output ready);
endinterface

// ===== rtl/fust_out_if.sv =====
// output channel: one report per transfer
`timescale 1ns / 1ps
interface fust_out_if;
    import fust_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] first_unique;
    logic             found;

    modport source (output valid, output first_unique, output found, input ready);
    modport sink   (input valid, input first_unique, input found, output ready);
endinterface

// ===== rtl/first_unique_symbol_tracker.sv =====
// top level: seen map, sequencer and chain of cells reporting the oldest unique symbol
// each input symbol steps the sequencer through look and done, or through look, find,
//   shift and done on a repeated symbol (the find and shift steps act on the cell
//   chain); no new symbol is taken until the last report is loaded, which may wait on the output side
// reset: synchronous, active low; clears seen map, chain occupancy, tail count and
//   output valid at once, with no clearing pass
`timescale 1ns / 1ps
module first_unique_symbol_tracker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fust_in_if.sink    i_in,
    fust_out_if.source o_out
);
    import fust_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic [SYM_W-1:0]         r_sym;
    logic                     r_start;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [ALPHABET_SIZE-1:0] r_seen;
    logic [ALPHABET_SIZE-1:0] n_seen;
    logic [IDX_W-1:0]         r_rm_idx;
    logic [IDX_W-1:0]         n_rm_idx;
    logic                     r_rm_any;
    logic                     r_out_valid;
    logic [SYM_W-1:0]         r_out_first;
    logic                     r_out_found;
    logic                     out_load;

    logic [SYM_W-1:0]         w_sym [ALPHABET_SIZE];
    logic                     w_valid [ALPHABET_SIZE];
    logic                     w_hit [ALPHABET_SIZE];
    logic [SYM_W-1:0]         w_next_sym [ALPHABET_SIZE];
    logic                     w_next_valid [ALPHABET_SIZE];

    t_cell_ctl                ctl;
    logic [IDX_W-1:0]         sym_idx;
    logic                     in_alpha;
    logic                     seen_bit;
    logic [CNT_W-1:0]         tail;
    logic                     hit_any;

    // lookup of the current symbol in the seen map
    assign sym_idx  = r_sym[IDX_W-1:0];
    assign in_alpha = ({1'b0, r_sym} < (SYM_W + 1)'(ALPHABET_SIZE));
    assign seen_bit = r_seen[sym_idx] && !r_start;
    assign tail     = r_start ? '0 : r_count;

    // encode the single matching cell into its position
    always_comb begin
        n_rm_idx = '0;
        hit_any  = 1'b0;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (w_hit[i]) begin
                n_rm_idx = n_rm_idx | IDX_W'(i);
                hit_any  = 1'b1;
            end
        end
    end

    // broadcast control to the chain
    always_comb begin
        ctl        = '0;
        ctl.sym    = r_sym;
        ctl.tail   = tail;
        ctl.rm_idx = r_rm_idx;
        ctl.clear  = (r_state == S_LOOK) && r_start;
        ctl.append = (r_state == S_LOOK) && in_alpha && !seen_bit;
        ctl.shift  = (r_state == S_SHIFT) && r_rm_any;
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // sequencer, tail count and seen map updates
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_seen  = r_seen;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_start) begin
                    n_seen  = '0;
                    n_count = '0;
                end
                if (in_alpha) begin
                    n_seen[sym_idx] = 1'b1;
                end
                if (in_alpha && !seen_bit) begin
                    n_count = (tail != CNT_W'(ALPHABET_SIZE)) ? tail + 1'b1 : tail;
                    n_state = S_DONE;
                end else if (in_alpha) begin
                    n_state = S_FIND;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_rm_any) begin
                    n_count = r_count - 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_seen  <= n_seen;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in.valid) begin
            r_sym   <= i_in.symbol;
            r_start <= i_in.start_of_stream;
        end
        if (r_state == S_FIND) begin
            r_rm_idx <= n_rm_idx;
            r_rm_any <= hit_any;
        end
        if (out_load) begin
            r_out_first <= w_valid[0] ? w_sym[0] : '0;
            r_out_found <= w_valid[0];
        end
    end

    // chain of cells, each at or above the removed entry pulling from its upper neighbor on removal
    for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
        if (g == ALPHABET_SIZE - 1) begin : g_last
            assign w_next_sym[g]   = '0;
            assign w_next_valid[g] = 1'b0;
        end else begin : g_mid
            assign w_next_sym[g]   = w_sym[g+1];
            assign w_next_valid[g] = w_valid[g+1];
        end

        fust_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_ctl        (ctl),
            .i_next_sym   (w_next_sym[g]),
            .i_next_valid (w_next_valid[g]),
            .o_sym        (w_sym[g]),
            .o_valid      (w_valid[g]),
            .o_hit        (w_hit[g])
        );
    end

    // channel outputs
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.first_unique = r_out_first;
    assign o_out.found        = r_out_found;
endmodule

// ===== rtl/fust_cell.sv =====
// one cell of the arrival-ordered chain of symbols seen exactly once
`timescale 1ns / 1ps
module fust_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [fust_pkg::IDX_W-1:0] i_index,
    input  fust_pkg::t_cell_ctl       i_ctl,
    input  logic [fust_pkg::SYM_W-1:0] i_next_sym,
    input  logic                      i_next_valid,
    output logic [fust_pkg::SYM_W-1:0] o_sym,
    output logic                      o_valid,
    output logic                      o_hit
);
    import fust_pkg::*;

    logic [SYM_W-1:0] r_sym;
    logic [SYM_W-1:0] n_sym;
    logic             r_valid;
    logic             n_valid;
    logic             r_hit;
    logic             append_here;
    logic             shift_here;

    // this cell is the tail slot, or lies at or above the removed entry
    assign append_here = i_ctl.append && ({1'b0, i_index} == CNT_W'({1'b0, i_index}))
                         && (CNT_W'(i_index) == i_ctl.tail);
    assign shift_here  = i_ctl.shift && (i_index >= i_ctl.rm_idx);

    // next contents: append, pull from upper neighbor, or clear
    always_comb begin
        n_sym   = r_sym;
        n_valid = r_valid;
        priority if (append_here) begin
            n_sym   = i_ctl.sym;
            n_valid = 1'b1;
        end else if (shift_here) begin
            n_sym   = i_next_sym;
            n_valid = i_next_valid;
        end else if (i_ctl.clear) begin
            n_valid = 1'b0;
        end
    end

    // symbol payload and registered match flag
    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_hit <= r_valid && (r_sym == i_ctl.sym);
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_sym   = r_sym;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;
endmodule
